// ===== design/midi_event_vlq_encoder_unit_macros.svh =====
// ---------------------------------------------------------------------------
// midi event vlq encoder assertion macros
// Shared property wrappers clocked on aclk and held off while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef MIDI_EVENT_VLQ_ENCODER_UNIT_MACROS_SVH
`define MIDI_EVENT_VLQ_ENCODER_UNIT_MACROS_SVH

// same-cycle implication
`define MEVLQ_ASSERT_SAME(lbl, ant, con) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (con)) \
        else $error("mevlq same-cycle check failed");

// next-cycle implication
`define MEVLQ_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (con)) \
        else $error("mevlq next-cycle check failed");

`endif

// ===== design/mevlq_pkg.sv =====
// ---------------------------------------------------------------------------
// mevlq_pkg
// Widths, byte slot codes and helpers for the MIDI event VLQ encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package mevlq_pkg;

    localparam int DELTA_W    = 28;
    localparam int BYTE_W     = 8;
    localparam int GROUP_W    = 7;
    localparam int NUM_GROUPS = 4;
    localparam int SLOT_W     = 3;

    localparam logic [BYTE_W-1:0] CONT_BIT = 8'h80;

    // byte slot codes within one event
    localparam logic [SLOT_W-1:0] SLOT_GRP0   = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_GRP1   = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_GRP2   = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_GRP3   = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_STATUS = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_DATA1  = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_DATA2  = 3'd6;

    // first non-zero 7-bit group, the lowest group is always kept
    function automatic logic [SLOT_W-1:0] first_slot(input logic [DELTA_W-1:0] delta);
        logic [SLOT_W-1:0] slot;
        if (delta[27:21] != 7'd0) begin
            slot = SLOT_GRP0;
        end else if (delta[20:14] != 7'd0) begin
            slot = SLOT_GRP1;
        end else if (delta[13:7] != 7'd0) begin
            slot = SLOT_GRP2;
        end else begin
            slot = SLOT_GRP3;
        end
        return slot;
    endfunction

endpackage

`default_nettype wire

// ===== design/midi_event_vlq_encoder_unit.sv =====
// ---------------------------------------------------------------------------
// midi_event_vlq_encoder_unit
// Turns one MIDI track event into its byte stream: the delta time as a
// variable-length quantity, then status, data1 and data2.
// ---------------------------------------------------------------------------
// An event is taken into a holding register and then sent one byte per cycle
// on the result channel while m_ready is high, one byte per group kept in the
// delta time and then status, data1 and data2. Each byte moves from the
// holding register into the result register before it is shown on m_out_byte.
// The next event is taken in the same cycle that the
// final byte of the current one moves into the result register, so with
// m_ready held high the bytes of consecutive events follow with no gap.
// m_last_of_event marks the data2 byte.
`default_nettype none

`include "midi_event_vlq_encoder_unit_macros.svh"

module midi_event_vlq_encoder_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [mevlq_pkg::DELTA_W-1:0]    s_delta_ticks,
    input  wire logic [mevlq_pkg::BYTE_W-1:0]     s_status_byte,
    input  wire logic [mevlq_pkg::BYTE_W-1:0]     s_data_first,
    input  wire logic [mevlq_pkg::BYTE_W-1:0]     s_data_second,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [mevlq_pkg::BYTE_W-1:0]          m_out_byte,
    output logic                                  m_last_of_event
);
    import mevlq_pkg::*;

    // holding register
    logic                  hold_valid_reg, hold_valid_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [DELTA_W-1:0]    delta_reg;
    logic [BYTE_W-1:0]     status_reg;
    logic [BYTE_W-1:0]     data1_reg;
    logic [BYTE_W-1:0]     data2_reg;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic                  out_last_reg;

    logic                  in_fire;
    logic                  out_adv;
    logic                  on_last;
    logic [BYTE_W-1:0]     sel_byte;

    // handshake
    assign out_adv = hold_valid_reg && (!out_valid_reg || m_ready);
    assign on_last = (slot_reg == SLOT_DATA2);
    assign s_ready = !hold_valid_reg || (out_adv && on_last);
    assign in_fire = s_valid && s_ready;

    // byte select for the current slot
    always_comb begin
        case (slot_reg)
            SLOT_GRP0:   sel_byte = CONT_BIT | {1'b0, delta_reg[27:21]};
            SLOT_GRP1:   sel_byte = CONT_BIT | {1'b0, delta_reg[20:14]};
            SLOT_GRP2:   sel_byte = CONT_BIT | {1'b0, delta_reg[13:7]};
            SLOT_GRP3:   sel_byte = {1'b0, delta_reg[6:0]};
            SLOT_STATUS: sel_byte = status_reg;
            SLOT_DATA1:  sel_byte = data1_reg;
            SLOT_DATA2:  sel_byte = data2_reg;
            default:     sel_byte = data2_reg;
        endcase
    end

    // holding control next state
    always_comb begin
        hold_valid_next = hold_valid_reg;
        slot_next       = slot_reg;
        if (in_fire) begin
            hold_valid_next = 1'b1;
            slot_next       = first_slot(s_delta_ticks);
        end else if (out_adv) begin
            if (on_last) begin
                hold_valid_next = 1'b0;
            end else begin
                slot_next = slot_reg + SLOT_W'(1);
            end
        end
    end

    // result valid next state
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_adv) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            slot_reg       <= SLOT_GRP3;
            out_valid_reg  <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            slot_reg       <= slot_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // event payload capture
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            delta_reg  <= s_delta_ticks;
            status_reg <= s_status_byte;
            data1_reg  <= s_data_first;
            data2_reg  <= s_data_second;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (out_adv) begin
            out_byte_reg <= sel_byte;
            out_last_reg <= on_last;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_byte      = out_byte_reg;
    assign m_last_of_event = out_last_reg;

    // checks
    `MEVLQ_ASSERT_SAME(a_slot_range, hold_valid_reg, slot_reg <= SLOT_DATA2)
    `MEVLQ_ASSERT_SAME(a_take_when_free, in_fire, !hold_valid_reg || on_last)
    `MEVLQ_ASSERT_NEXT(a_last_flagged, out_adv && on_last, m_valid && m_last_of_event)
    `MEVLQ_ASSERT_NEXT(a_cont_bit, out_adv && slot_reg < SLOT_GRP3, m_out_byte[BYTE_W-1])

endmodule

`default_nettype wire
